[sv/fpa_pkg.sv]
// Shared types, opcodes and constants for the Q16.16 fixed-point ALU.
package fpa_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int DVD_W   = DATA_W + FRAC_W;
    localparam int STEPS   = DVD_W;
    localparam int Q_DEPTH = 4;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);

    localparam logic [DATA_W-1:0] TRUE_WORD = 32'hFFFF_0000;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0,  OP_SUB = 5'd1,  OP_MUL = 5'd2,  OP_DIV = 5'd3,
        OP_MOD = 5'd4,  OP_SHL = 5'd5,  OP_SHR = 5'd6,  OP_AND = 5'd7,
        OP_OR  = 5'd8,  OP_EQ  = 5'd9,  OP_NE  = 5'd10, OP_LT  = 5'd11,
        OP_LE  = 5'd12, OP_GT  = 5'd13, OP_GE  = 5'd14, OP_NEG = 5'd15,
        OP_NOT = 5'd16
    } op_t;

    // Where the back end takes the result from
    typedef enum logic [1:0] {
        KIND_DIRECT = 2'd0,
        KIND_MUL    = 2'd1,
        KIND_DIV    = 2'd2,
        KIND_MOD    = 2'd3
    } kind_t;

    // Compare code bits: less, equal, greater
    localparam logic [2:0] CMP_LT = 3'b001;
    localparam logic [2:0] CMP_EQ = 3'b010;
    localparam logic [2:0] CMP_GT = 3'b100;

    // Relational masks for eq, ne, lt, le, gt, ge
    localparam logic [2:0] REL_MASK [0:5] = '{3'd2, 3'd5, 3'd1, 3'd3, 3'd4, 3'd6};

    // One classified operation, as queued between front and back
    typedef struct packed {
        kind_t              kind;
        logic               status;
        logic [DATA_W-1:0]  value;   // direct result, or left factor
        logic [DATA_W-1:0]  dvs;     // divisor magnitude, or right factor
        logic [DVD_W-1:0]   dvd;     // dividend magnitude
        logic               qneg;    // negate the quotient
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[sv/fpa_front.sv]
// Front end: decodes an operation, computes the direct-result ops, preps multiply and divide operands.
module fpa_front
    import fpa_pkg::*;
(
    input  logic [4:0]        req_type,
    input  logic [DATA_W-1:0] operand_a,
    input  logic [DATA_W-1:0] operand_b,
    output entry_t            entry
);

    logic [15:0]       int_a;
    logic [15:0]       int_b;
    logic [15:0]       amt;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [2:0]        cmp;
    logic [2:0]        rel_idx;

    assign int_a = operand_a[DATA_W-1:FRAC_W];
    assign int_b = operand_b[DATA_W-1:FRAC_W];
    assign amt   = int_b;
    assign mag_a = operand_a[DATA_W-1] ? (~operand_a + 1'b1) : operand_a;
    assign mag_b = operand_b[DATA_W-1] ? (~operand_b + 1'b1) : operand_b;
    assign rel_idx = 3'(req_type - 5'(OP_EQ));

    // Classify a signed compare as less, equal or greater
    always_comb begin
        if (operand_a == operand_b) begin
            cmp = CMP_EQ;
        end else if ($signed(operand_a) > $signed(operand_b)) begin
            cmp = CMP_GT;
        end else begin
            cmp = CMP_LT;
        end
    end

    // Decode and compute
    always_comb begin
        entry        = '0;
        entry.kind   = KIND_DIRECT;
        case (op_t'(req_type))
            OP_ADD: entry.value = operand_a + operand_b;
            OP_SUB: entry.value = operand_a - operand_b;
            OP_MUL: begin
                entry.kind  = KIND_MUL;
                entry.value = operand_a;
                entry.dvs   = operand_b;
            end
            OP_DIV: begin
                entry.kind   = KIND_DIV;
                entry.status = (operand_b == '0);
                entry.dvd    = {mag_a, {FRAC_W{1'b0}}};
                entry.dvs    = mag_b;
                entry.qneg   = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
            end
            OP_MOD: begin
                entry.kind   = KIND_MOD;
                entry.status = (int_b == '0);
                entry.dvd    = DVD_W'(int_a);
                entry.dvs    = DATA_W'(int_b);
            end
            OP_SHL: begin
                entry.value = (amt >= 16'd32) ? '0 : (operand_a << amt[4:0]);
            end
            OP_SHR: begin
                entry.value = (amt >= 16'd32) ? {DATA_W{operand_a[DATA_W-1]}}
                                              : DATA_W'($signed(operand_a) >>> amt[4:0]);
            end
            OP_AND: entry.value = {int_a & int_b, {FRAC_W{1'b0}}};
            OP_OR:  entry.value = {int_a | int_b, {FRAC_W{1'b0}}};
            OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
                entry.value = ((cmp & REL_MASK[rel_idx]) != '0) ? TRUE_WORD : '0;
            end
            OP_NEG: entry.value = ~operand_a + 1'b1;
            OP_NOT: entry.value = (operand_a & TRUE_WORD) ^ TRUE_WORD;
            default: entry.value = '0;
        endcase
    end

endmodule

[sv/fpa_queue.sv]
// Short queue that decouples the front end from the back-end pipeline.
module fpa_queue
    import fpa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  entry_t  push_data,
    input  logic    pop,
    output entry_t  head,
    output q_stat_t stat
);

    entry_t               mem_reg [0:Q_DEPTH-1];
    logic [Q_IDX_W-1:0]   wr_reg, wr_next;
    logic [Q_IDX_W-1:0]   rd_reg, rd_next;
    logic [Q_IDX_W:0]     cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == (Q_IDX_W+1)'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head       = mem_reg[rd_reg];

    // Advance pointers and count
    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (Q_IDX_W+1)'(push) - (Q_IDX_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the incoming entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

[sv/fpa_back.sv]
// Back end: multiplier stage, one-bit-per-stage divider pipeline and output register.
module fpa_back
    import fpa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  entry_t            head,
    input  logic              head_valid,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_value,
    output logic              out_status
);

    typedef struct packed {
        entry_t            e;
        logic [DATA_W-1:0] rem;
    } stage_t;

    stage_t            pipe_reg [0:STEPS];
    logic              vld_reg  [0:STEPS];
    stage_t            load;
    logic [63:0]       prod;
    logic              adv;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic              out_status_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && head_valid;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_status = out_status_reg;

    // One restoring-division step: bring down a dividend bit, shift in a quotient bit
    function automatic stage_t div_step(stage_t s);
        stage_t          r;
        logic [DATA_W:0] trial;
        logic [DATA_W:0] diff;
        r     = s;
        trial = {s.rem, s.e.dvd[DVD_W-1]};
        diff  = trial - {1'b0, s.e.dvs};
        if (trial >= {1'b0, s.e.dvs}) begin
            r.rem   = diff[DATA_W-1:0];
            r.e.dvd = {s.e.dvd[DVD_W-2:0], 1'b1};
        end else begin
            r.rem   = trial[DATA_W-1:0];
            r.e.dvd = {s.e.dvd[DVD_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Form the product on entry to the pipeline
    always_comb begin
        prod = 64'($signed(head.value) * $signed(head.dvs));
        load.e   = head;
        load.rem = '0;
        if (head.kind == KIND_MUL) begin
            load.e.value = prod[DVD_W-1:FRAC_W];
        end
    end

    // Pick the result at the end of the pipeline
    always_comb begin
        case (pipe_reg[STEPS].e.kind)
            KIND_DIRECT, KIND_MUL: out_value_next = pipe_reg[STEPS].e.value;
            KIND_DIV: begin
                if (pipe_reg[STEPS].e.status) begin
                    out_value_next = '0;
                end else if (pipe_reg[STEPS].e.qneg) begin
                    out_value_next = ~pipe_reg[STEPS].e.dvd[DATA_W-1:0] + 1'b1;
                end else begin
                    out_value_next = pipe_reg[STEPS].e.dvd[DATA_W-1:0];
                end
            end
            KIND_MOD: begin
                out_value_next = pipe_reg[STEPS].e.status ? '0
                               : {pipe_reg[STEPS].rem[15:0], {FRAC_W{1'b0}}};
            end
            default: out_value_next = '0;
        endcase
    end

    // Advance valid bits when the output can take a transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= STEPS; k++) begin
                vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= pop;
            for (int k = 0; k < STEPS; k++) begin
                vld_reg[k+1] <= vld_reg[k];
            end
            out_valid_reg <= vld_reg[STEPS];
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_reg[0] <= load;
            for (int k = 0; k < STEPS; k++) begin
                pipe_reg[k+1] <= div_step(pipe_reg[k]);
            end
            out_value_reg  <= out_value_next;
            out_status_reg <= pipe_reg[STEPS].e.status;
        end
    end

endmodule

[sv/fixed_point_16_16_alu.sv]
// Path from input transfer to result valid: queue write on the transfer edge, then the
// product stage, 48 divider stages, output register; every operation takes this path.
// Throughput: one operation per cycle unless output stalls; one quotient bit per stage.
// The whole back pipeline holds while the output is stalled; the queue absorbs input.
// Reset: aresetn is synchronous, active low, and empties queue and pipeline.
// No configuration and no kept state between operations.
module fixed_point_16_16_alu
    import fpa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [4:0] req_type, [36:5] operand_a, [68:37] operand_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic        m_tuser    // [0] result_status
);

    entry_t  f_entry;
    entry_t  q_head;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    fpa_front u_front (
        .req_type  (s_tdata[4:0]),
        .operand_a (s_tdata[36:5]),
        .operand_b (s_tdata[68:37]),
        .entry     (f_entry)
    );

    fpa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (f_entry),
        .pop       (pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    fpa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (m_tdata),
        .out_status (m_tuser)
    );

    // An error result always carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result with nonzero value");

    // Queue is never both full and empty
    a_q_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // Reset leaves no result pending
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
